// File: hw/rtl/dsvs_pkg.sv
// ----------------------------------------------------------------------------
// dsvs_pkg
// Types, register indexes, reset values and saturation helpers shared by the
// damped string Verlet step block, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package dsvs_pkg;

  typedef logic signed [31:0] q_t;
  typedef logic signed [25:0] sample_t;
  typedef logic [46:0]        energy_t;
  typedef logic [1:0]         action_t;
  typedef logic [7:0]         node_t;
  typedef logic [2:0]         cfg_index_t;

  localparam action_t ACT_LOAD = 2'd0;
  localparam action_t ACT_STEP = 2'd1;
  localparam action_t ACT_READ = 2'd2;
  localparam action_t ACT_NONE = 2'd3;

  localparam cfg_index_t REG_LAPLACE_GAIN   = 3'd0;
  localparam cfg_index_t REG_DAMPING_GAIN   = 3'd1;
  localparam cfg_index_t REG_DRIVE_GAIN     = 3'd2;
  localparam cfg_index_t REG_HALF_STEP      = 3'd3;
  localparam cfg_index_t REG_FULL_STEP      = 3'd4;
  localparam cfg_index_t REG_CELL_WIDTH     = 3'd5;
  localparam cfg_index_t REG_INV_CELL_WIDTH = 3'd6;
  localparam cfg_index_t REG_DRIVE_NODE     = 3'd7;

  localparam q_t    RST_LAPLACE_GAIN   = 32'sd1677721600;
  localparam q_t    RST_DAMPING_GAIN   = 32'sd335544320;
  localparam q_t    RST_DRIVE_GAIN     = 32'sd16777216;
  localparam q_t    RST_HALF_STEP      = 32'sd419430;
  localparam q_t    RST_FULL_STEP      = 32'sd838861;
  localparam q_t    RST_CELL_WIDTH     = 32'sd1677722;
  localparam q_t    RST_INV_CELL_WIDTH = 32'sd167772160;
  localparam node_t RST_DRIVE_NODE     = 8'd75;

  localparam energy_t ENERGY_MAX = '1;

  localparam logic signed [63:0] Q_HI = 64'sd2147483647;
  localparam logic signed [63:0] Q_LO = -64'sd2147483648;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DRIVE,
    ST_PRO,
    ST_NODE,
    ST_EDGE,
    ST_SCALE,
    ST_RESP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PASS_KICK,
    PASS_SETTLE,
    PASS_ENERGY
  } pass_t;

  function automatic q_t sat32(input logic signed [63:0] x);
    q_t r;
    if (x > Q_HI) begin
      r = 32'sh7fffffff;
    end else if (x < Q_LO) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/dsvs_ifs.sv
// ----------------------------------------------------------------------------
// dsvs channel interfaces
// Valid/ready channels for the action items and the result items.
// ----------------------------------------------------------------------------
interface dsvs_in_if;
  import dsvs_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  node_t   node_index;
  q_t      load_value;
  sample_t drive_sample;

  modport source (output valid, action, node_index, load_value, drive_sample,
                  input ready);
  modport sink   (input valid, action, node_index, load_value, drive_sample,
                  output ready);
endinterface

interface dsvs_out_if;
  import dsvs_pkg::*;

  logic    valid;
  logic    ready;
  q_t      displacement_out;
  q_t      velocity_out;
  energy_t energy_out;

  modport source (output valid, displacement_out, velocity_out, energy_out,
                  input ready);
  modport sink   (input valid, displacement_out, velocity_out, energy_out,
                  output ready);
endinterface

// File: hw/rtl/damped_string_verlet_step_top.sv
// ----------------------------------------------------------------------------
// damped_string_verlet_step_top
// Damped string of POINTS nodes advanced by velocity-Verlet steps, Q8.24.
// ----------------------------------------------------------------------------
// One item at a time. In a step every node goes through one shared 32x32
// multiplier in each of three passes: kick-and-drift, settle and energy.
// After reset the block clears the current displacement bank and the
// velocity memory and takes no item meanwhile; configuration writes are
// taken at any time. Displacement lives in two banks: a step writes the new
// displacement to the spare bank, keeps the old one for the damping term,
// then swaps banks. A finished result sits in an output register, so the
// next item is taken while it waits for its transfer.
// ----------------------------------------------------------------------------
module damped_string_verlet_step_top #(
  parameter int POINTS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  dsvs_pkg::cfg_index_t   cfg_index,
  input  dsvs_pkg::q_t           cfg_data,
  dsvs_in_if.sink                item,
  dsvs_out_if.source             result
);
  import dsvs_pkg::*;

  localparam int AW = $clog2(POINTS);
  // energy accumulator: each node adds below 2^39
  localparam int SW = 40 + AW;

  // configuration
  q_t    laplace_gain, damping_gain, drive_gain, half_step, full_step;
  q_t    cell_width, inv_cell_width;
  node_t drive_node;

  // control
  state_t        state, state_next;
  pass_t         pass, pass_next;
  logic [2:0]    ph, ph_next;
  logic [AW-1:0] n, n_next;
  logic          b, b_next;
  logic          edge_last, edge_last_next;

  // captured item
  action_t act_r;
  node_t   node_r;
  q_t      load_r;
  sample_t sample_r;

  // datapath
  q_t                 um, uc, up, d2, du, vcur, acc, lapt, hvr, drive;
  logic signed [63:0] prod;
  logic [63:0]        sq, esum;
  logic [SW-1:0]      s;
  q_t                 res_d, res_v;
  energy_t            res_e;

  // memories
  q_t disp0 [POINTS];
  q_t disp1 [POINTS];
  q_t vel   [POINTS];
  q_t hvel  [POINTS];
  q_t b0_q, b1_q, v_q, h_q;

  logic          a_we, o_we, v_we, h_we;
  logic [AW-1:0] a_raddr, o_raddr, v_raddr, h_raddr;
  logic [AW-1:0] a_waddr, o_waddr, v_waddr, h_waddr;
  q_t            a_wdata, o_wdata, v_wdata, h_wdata;
  logic          b0_we, b1_we;
  logic [AW-1:0] b0_raddr, b1_raddr, b0_waddr, b1_waddr;
  q_t            b0_wdata, b1_wdata;
  q_t            act_q, oth_q, nb;

  q_t mul_a, mul_b;

  // derived values
  logic          accept, out_free, in_rng, node_end, last_node, node_done;
  logic [AW-1:0] node_a, n_inc;
  logic [2:0]    ph_end;
  q_t            q24, q25, drv, lap_d2, nb_dg, old_du, edge_d;
  logic signed [63:0] e_sum;

  assign accept   = item.valid && item.ready;
  assign out_free = !result.valid || result.ready;
  assign in_rng   = 32'(node_r) < POINTS;
  assign node_a   = AW'(node_r);
  assign node_end = (node_a == '0) || (node_a == AW'(POINTS - 1));
  assign n_inc    = AW'(n + 1'b1);
  assign last_node = n == AW'(POINTS - 2);
  assign ph_end   = (pass == PASS_KICK) ? 3'd7 : (pass == PASS_SETTLE) ? 3'd6 : 3'd5;
  assign node_done = ph == ph_end;

  // bank mapping: b selects which bank holds the current displacement
  assign act_q = b ? b1_q : b0_q;
  assign oth_q = b ? b0_q : b1_q;
  assign nb    = (pass == PASS_SETTLE) ? oth_q : act_q;

  assign b0_raddr = b ? o_raddr : a_raddr;
  assign b1_raddr = b ? a_raddr : o_raddr;
  assign b0_we    = b ? o_we : a_we;
  assign b1_we    = b ? a_we : o_we;
  assign b0_waddr = b ? o_waddr : a_waddr;
  assign b1_waddr = b ? a_waddr : o_waddr;
  assign b0_wdata = b ? o_wdata : a_wdata;
  assign b1_wdata = b ? a_wdata : o_wdata;

  // product scaling and per-node sums
  assign q24    = sat32(prod >>> 24);
  assign q25    = sat32(prod >>> 25);
  assign drv    = (32'(n) == 32'(drive_node)) ? drive : '0;
  assign lap_d2 = sat32(64'(nb) - (64'(uc) <<< 1) + 64'(um));
  assign nb_dg  = sat32(64'(nb) - 64'(um));
  assign old_du = sat32(64'(uc) - 64'(act_q));
  assign edge_d = sat32(64'(uc) - 64'(um));
  assign e_sum  = sq + (prod >>> 24);

  always_ff @(posedge clk) begin
    if (b0_we) begin
      disp0[b0_waddr] <= b0_wdata;
    end
    b0_q <= disp0[b0_raddr];
  end

  always_ff @(posedge clk) begin
    if (b1_we) begin
      disp1[b1_waddr] <= b1_wdata;
    end
    b1_q <= disp1[b1_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vel[v_waddr] <= v_wdata;
    end
    v_q <= vel[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hvel[h_waddr] <= h_wdata;
    end
    h_q <= hvel[h_raddr];
  end

  // next state, phase, node and pass
  always_comb begin
    state_next     = state;
    ph_next        = ph + 3'd1;
    n_next         = n;
    pass_next      = pass;
    b_next         = b;
    edge_last_next = edge_last;
    case (state)
      ST_CLEAR: begin
        ph_next = '0;
        n_next  = n_inc;
        if (n == AW'(POINTS - 1)) begin
          n_next     = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ph_next = '0;
        if (accept) begin
          case (item.action)
            ACT_LOAD: state_next = ST_LOAD;
            ACT_STEP: state_next = ST_DRIVE;
            default:  state_next = ST_RESP;
          endcase
        end
      end
      ST_LOAD: begin
        ph_next    = '0;
        state_next = ST_RESP;
      end
      ST_DRIVE: begin
        if (ph == 3'd1) begin
          ph_next    = '0;
          pass_next  = PASS_KICK;
          state_next = ST_PRO;
        end
      end
      ST_PRO: begin
        if (ph == 3'd2) begin
          ph_next = '0;
          n_next  = AW'(1);
          if (pass == PASS_ENERGY) begin
            edge_last_next = 1'b0;
            state_next     = ST_EDGE;
          end else begin
            state_next = ST_NODE;
          end
        end
      end
      ST_NODE: begin
        if (node_done) begin
          ph_next = '0;
          n_next  = n_inc;
          if (last_node) begin
            case (pass)
              PASS_KICK: begin
                pass_next  = PASS_SETTLE;
                state_next = ST_PRO;
              end
              PASS_SETTLE: begin
                pass_next  = PASS_ENERGY;
                b_next     = ~b;
                state_next = ST_PRO;
              end
              default: begin
                edge_last_next = 1'b1;
                state_next     = ST_EDGE;
              end
            endcase
          end
        end
      end
      ST_EDGE: begin
        if (ph == 3'd4) begin
          ph_next    = '0;
          state_next = edge_last ? ST_SCALE : ST_NODE;
        end
      end
      ST_SCALE: begin
        if (ph == 3'd3) begin
          ph_next    = '0;
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (ph == 3'd1) begin
          ph_next    = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        ph_next = '0;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory ports, multiplier operands, ready
  always_comb begin
    item.ready = 1'b0;
    a_we = 1'b0; o_we = 1'b0; v_we = 1'b0; h_we = 1'b0;
    a_waddr = n; o_waddr = n; v_waddr = n; h_waddr = n;
    a_wdata = '0; o_wdata = '0; v_wdata = '0; h_wdata = hvr;
    a_raddr = n; o_raddr = n; v_raddr = n; h_raddr = n;
    mul_a = '0; mul_b = '0;
    case (state)
      ST_CLEAR: begin
        a_we = 1'b1;
        v_we = 1'b1;
      end
      ST_IDLE: begin
        item.ready = 1'b1;
      end
      ST_LOAD: begin
        a_waddr = node_a;
        v_waddr = node_a;
        a_we    = in_rng;
        v_we    = in_rng;
        a_wdata = node_end ? '0 : load_r;
      end
      ST_DRIVE: begin
        mul_a = drive_gain;
        mul_b = 32'(sample_r);
      end
      ST_PRO: begin
        // window fill from node 0 and 1; the spare bank gets zero end nodes
        if (pass == PASS_SETTLE) begin
          o_raddr = (ph == 3'd0) ? '0 : AW'(1);
        end else begin
          a_raddr = (ph == 3'd0) ? '0 : AW'(1);
        end
        if (pass == PASS_KICK && ph != 3'd2) begin
          o_we    = 1'b1;
          o_waddr = (ph == 3'd0) ? '0 : AW'(POINTS - 1);
        end
      end
      ST_NODE: begin
        if (pass == PASS_SETTLE) begin
          o_raddr = n_inc;
        end else begin
          a_raddr = n_inc;
        end
        case (pass)
          PASS_KICK: begin
            case (ph)
              3'd2: begin mul_a = laplace_gain; mul_b = d2; end
              3'd4: begin mul_a = half_step;    mul_b = acc; end
              3'd6: begin
                mul_a = full_step;
                mul_b = hvr;
                h_we  = 1'b1;
              end
              3'd7: begin
                o_we    = 1'b1;
                o_wdata = sat32(64'(uc) + 64'(q24));
              end
              default: ;
            endcase
          end
          PASS_SETTLE: begin
            case (ph)
              3'd2: begin mul_a = laplace_gain; mul_b = d2; end
              3'd3: begin mul_a = damping_gain; mul_b = du; end
              3'd5: begin mul_a = half_step;    mul_b = acc; end
              3'd6: begin
                v_we    = 1'b1;
                v_wdata = sat32(64'(vcur) + 64'(q24));
              end
              default: ;
            endcase
          end
          default: begin
            case (ph)
              3'd2: begin mul_a = inv_cell_width; mul_b = d2; end
              3'd3: begin mul_a = vcur;           mul_b = vcur; end
              3'd4: begin mul_a = acc;            mul_b = acc; end
              default: ;
            endcase
          end
        endcase
      end
      ST_EDGE: begin
        case (ph)
          3'd1: begin mul_a = inv_cell_width; mul_b = d2; end
          3'd3: begin mul_a = acc;            mul_b = acc; end
          default: ;
        endcase
      end
      ST_SCALE: begin
        case (ph)
          3'd1: begin mul_a = 32'(s >> 24);  mul_b = cell_width; end
          3'd2: begin mul_a = 32'(s[23:0]);  mul_b = cell_width; end
          default: ;
        endcase
      end
      ST_RESP: begin
        a_raddr = node_a;
        v_raddr = node_a;
      end
      default: ;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      pass           <= PASS_KICK;
      ph             <= '0;
      n              <= '0;
      b              <= 1'b0;
      edge_last      <= 1'b0;
      result.valid   <= 1'b0;
      laplace_gain   <= RST_LAPLACE_GAIN;
      damping_gain   <= RST_DAMPING_GAIN;
      drive_gain     <= RST_DRIVE_GAIN;
      half_step      <= RST_HALF_STEP;
      full_step      <= RST_FULL_STEP;
      cell_width     <= RST_CELL_WIDTH;
      inv_cell_width <= RST_INV_CELL_WIDTH;
      drive_node     <= RST_DRIVE_NODE;
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      ph        <= ph_next;
      n         <= n_next;
      b         <= b_next;
      edge_last <= edge_last_next;
      // hold the result until its transfer, then drop valid
      if (state == ST_DONE && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LAPLACE_GAIN:   laplace_gain   <= cfg_data;
          REG_DAMPING_GAIN:   damping_gain   <= cfg_data;
          REG_DRIVE_GAIN:     drive_gain     <= cfg_data;
          REG_HALF_STEP:      half_step      <= cfg_data;
          REG_FULL_STEP:      full_step      <= cfg_data;
          REG_CELL_WIDTH:     cell_width     <= cfg_data;
          REG_INV_CELL_WIDTH: inv_cell_width <= cfg_data;
          REG_DRIVE_NODE:     drive_node     <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          act_r    <= item.action;
          node_r   <= item.node_index;
          load_r   <= item.load_value;
          sample_r <= item.drive_sample;
          res_e    <= '0;
        end
      end
      ST_DRIVE: begin
        if (ph == 3'd1) begin
          drive <= q24;
          s     <= '0;
          esum  <= '0;
        end
      end
      ST_PRO: begin
        if (ph == 3'd1) begin
          um <= nb;
        end
        if (ph == 3'd2) begin
          uc <= nb;
        end
      end
      ST_NODE: begin
        if (ph == 3'd1) begin
          up   <= nb;
          vcur <= (pass == PASS_SETTLE) ? h_q : v_q;
          d2   <= (pass == PASS_ENERGY) ? nb_dg : lap_d2;
          du   <= old_du;
        end
        case (pass)
          PASS_KICK: begin
            if (ph == 3'd3) acc <= sat32(64'(q24) + 64'(drv));
            if (ph == 3'd5) hvr <= sat32(64'(vcur) + 64'(q24));
          end
          PASS_SETTLE: begin
            if (ph == 3'd3) lapt <= q24;
            if (ph == 3'd4) acc  <= sat32(64'(lapt) - 64'(q24) + 64'(drv));
          end
          default: begin
            if (ph == 3'd3) acc <= q25;
            if (ph == 3'd4) sq  <= $unsigned(prod);
            if (ph == 3'd5) s   <= s + SW'((sq + $unsigned(prod)) >> 25);
          end
        endcase
        // slide the three-node window
        if (node_done) begin
          um <= uc;
          uc <= up;
        end
      end
      ST_EDGE: begin
        if (ph == 3'd0) d2   <= edge_d;
        if (ph == 3'd2) acc  <= q24;
        if (ph == 3'd4) esum <= esum + $unsigned(prod);
      end
      ST_SCALE: begin
        if (ph == 3'd0) s  <= s + SW'(esum >> 26);
        if (ph == 3'd2) sq <= $unsigned(prod);
        if (ph == 3'd3) begin
          if (cell_width <= 0) begin
            res_e <= '0;
          end else if (e_sum > 64'(ENERGY_MAX)) begin
            res_e <= ENERGY_MAX;
          end else begin
            res_e <= e_sum[46:0];
          end
        end
      end
      ST_RESP: begin
        if (ph == 3'd1) begin
          res_d <= (in_rng && act_r != ACT_NONE) ? act_q : '0;
          res_v <= (in_rng && act_r != ACT_NONE) ? v_q : '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          result.displacement_out <= res_d;
          result.velocity_out     <= res_v;
          result.energy_out       <= res_e;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/dsvs_checker.sv
// ----------------------------------------------------------------------------
// dsvs_checker
// Port-level checks for the damped string Verlet step block.
// ----------------------------------------------------------------------------
module dsvs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dsvs_pkg::q_t      displacement_out,
  input dsvs_pkg::q_t      velocity_out,
  input dsvs_pkg::energy_t energy_out
);
  import dsvs_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(displacement_out) && $stable(velocity_out) && $stable(energy_out))
    else $error("stalled result changed");

  // ready drops after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while the previous one is in work");

  // reset starts the clearing pass with nothing offered
  a_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block active right after reset");

endmodule

bind damped_string_verlet_step_top dsvs_checker u_dsvs_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (item.valid),
  .in_ready         (item.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .displacement_out (result.displacement_out),
  .velocity_out     (result.velocity_out),
  .energy_out       (result.energy_out)
);
